@@ design/interrupt_tree_slot_allocator_assert.svh @@
// Assertion macros used by the slot allocator sequencer.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef INTERRUPT_TREE_SLOT_ALLOCATOR_ASSERT_SVH
`define INTERRUPT_TREE_SLOT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define ITSA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ITSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/itsa_pkg.sv @@
// Shared constants for the interrupt tree slot allocator.
// No dependencies.
`timescale 1ns / 1ps

package itsa_pkg;

  localparam int unsigned TopLevelDef  = 5;
  localparam int unsigned LoadWidthDef = 16;
  localparam int unsigned IntervalW    = 8;
  localparam int unsigned SlotW        = 6;

endpackage

@@ design/itsa_if.sv @@
// Request and response channel interfaces of the slot allocator.
// Depends on itsa_pkg for the payload widths.
`timescale 1ns / 1ps

interface itsa_req_if import itsa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [IntervalW-1:0] interval;

  modport source (output valid, output interval, input ready);
  modport sink   (input valid, input interval, output ready);
endinterface

interface itsa_rsp_if import itsa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SlotW-1:0] slot;

  modport source (output valid, output slot, input ready);
  modport sink   (input valid, input slot, output ready);
endinterface

@@ design/interrupt_tree_slot_allocator.sv @@
// Interrupt tree slot allocator, least-load path search over a heap of
// load counters.
//
// Channels: req_i carries one polling interval per request; rsp_o returns
// the heap index of the chosen tree node, one response per request, in order.
// The level is the exponent of the largest power of two not above the
// interval, capped at TopLevel. Every path from a node of that level to the
// root is summed, the lightest path wins (lowest index on a tie), and its
// counters are bumped, saturating at full scale.
//
// The counter store has a single read port: one counter is read per cycle,
// first for every path during the scan, then for the winning path during the
// bump.
// req_i.ready is high only while no request is in work. The response sits in
// an output register, so a new request is taken while it waits; a stalled
// receiver holds the next finished request in its last state until the
// register frees. Reset clears all counters at once and empties the channels.
`timescale 1ns / 1ps

module interrupt_tree_slot_allocator import itsa_pkg::*; #(
  parameter int unsigned TopLevel  = TopLevelDef,
  parameter int unsigned LoadWidth = LoadWidthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  itsa_req_if.sink   req_i,
  itsa_rsp_if.source rsp_o
);

  localparam int unsigned NodeW = TopLevel + 1;
  localparam int unsigned Nodes = (2 ** (TopLevel + 1)) - 1;

  logic                 rd_en;
  logic [NodeW-1:0]     rd_addr;
  logic [LoadWidth-1:0] rd_data;
  logic                 wr_en;
  logic [NodeW-1:0]     wr_addr;
  logic [LoadWidth-1:0] wr_data;
  logic                 res_valid;
  logic                 res_ready;
  logic [NodeW-1:0]     res_node;

  logic             out_valid_q;
  logic [SlotW-1:0] slot_q;

  itsa_load_mem #(
    .Nodes (Nodes),
    .AddrW (NodeW),
    .DataW (LoadWidth)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  itsa_seq #(
    .TopLevel  (TopLevel),
    .LoadWidth (LoadWidth),
    .NodeW     (NodeW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .interval_i  (req_i.interval),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_node_o  (res_node),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  // Load the output register when it is empty or being drained.
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      slot_q <= SlotW'(res_node);
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.slot  = slot_q;

endmodule

@@ design/itsa_load_mem.sv @@
// Load counter store: one write port, one registered read port.
// Entries read as zero until first written after reset; depends on nothing.
`timescale 1ns / 1ps

module itsa_load_mem #(
  parameter int unsigned Nodes = 63,
  parameter int unsigned AddrW = 6,
  parameter int unsigned DataW = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [DataW-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_data_i
);

  logic [DataW-1:0] mem_q [Nodes];
  logic [Nodes-1:0] valid_q;
  logic [DataW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  // Unwritten entries hold the reset value of zero.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= valid_q[rd_addr_i] ? mem_q[rd_addr_i] : '0;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ design/itsa_seq.sv @@
// Sequencer for the least-load search: walks every path of the chosen level
// through one shared adder, then bumps the winning path. Uses itsa_pkg.
`timescale 1ns / 1ps

module itsa_seq import itsa_pkg::*; #(
  parameter int unsigned TopLevel  = TopLevelDef,
  parameter int unsigned LoadWidth = LoadWidthDef,
  parameter int unsigned NodeW     = TopLevel + 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [IntervalW-1:0] interval_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output logic [NodeW-1:0]     res_node_o,
  output logic                 rd_en_o,
  output logic [NodeW-1:0]     rd_addr_o,
  input  logic [LoadWidth-1:0] rd_data_i,
  output logic                 wr_en_o,
  output logic [NodeW-1:0]     wr_addr_o,
  output logic [LoadWidth-1:0] wr_data_o
);

  localparam int unsigned LvlW = (TopLevel + 1 > 1) ? $clog2(TopLevel + 1) : 1;
  localparam int unsigned SumW = LoadWidth + $clog2(TopLevel + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_BUMP = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [LvlW-1:0]  lev_q, lev_d;
  logic [LvlW-1:0]  step_q, step_d;
  logic [NodeW-1:0] walk_q, walk_d;
  logic [NodeW-1:0] leaf_q, leaf_d;
  logic [NodeW-1:0] last_leaf_q, last_leaf_d;
  logic             issue_done_q, issue_done_d;
  logic             tag_valid_q, tag_valid_d;
  logic             tag_first_q, tag_first_d;
  logic             tag_last_q, tag_last_d;
  logic [NodeW-1:0] tag_node_q, tag_node_d;
  logic [SumW-1:0]  acc_q, acc_d;
  logic [SumW-1:0]  best_sum_q, best_sum_d;
  logic [NodeW-1:0] best_q, best_d;
  logic             have_q, have_d;

  logic [2:0]       msb;
  logic [LvlW-1:0]  pick_lev;
  logic [SumW-1:0]  add_a;
  logic [SumW-1:0]  add_sum;
  logic [NodeW-1:0] parent;
  logic             walking;

  // Level: highest set bit of the interval, capped at the top level.
  always_comb begin
    msb = '0;
    for (int i = 1; i < IntervalW; i++) begin
      if (interval_i[i]) begin
        msb = 3'(i);
      end
    end
    pick_lev = (int'(msb) > TopLevel) ? LvlW'(TopLevel) : LvlW'(msb);
  end

  assign walking = (state_q == ST_SCAN) || (state_q == ST_BUMP);
  assign parent  = NodeW'((({1'b0, walk_q} + 1'b1) >> 1) - 1'b1);

  // Shared adder: path accumulation during the scan, increment during the bump.
  assign add_a   = (state_q == ST_BUMP) ? SumW'(1) : (tag_first_q ? '0 : acc_q);
  assign add_sum = add_a + SumW'(rd_data_i);

  assign rd_en_o   = walking && !issue_done_q;
  assign rd_addr_o = walk_q;
  assign wr_en_o   = (state_q == ST_BUMP) && tag_valid_q;
  assign wr_addr_o = tag_node_q;
  assign wr_data_o = (rd_data_i == '1) ? rd_data_i : add_sum[LoadWidth-1:0];

  assign in_ready_o  = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_FIN);
  assign res_node_o  = best_q;

  always_comb begin
    state_d      = state_q;
    lev_d        = lev_q;
    step_d       = step_q;
    walk_d       = walk_q;
    leaf_d       = leaf_q;
    last_leaf_d  = last_leaf_q;
    issue_done_d = issue_done_q;
    tag_valid_d  = rd_en_o;
    tag_first_d  = (step_q == '0);
    tag_last_d   = (step_q == lev_q);
    tag_node_d   = (state_q == ST_SCAN) ? leaf_q : walk_q;
    acc_d        = acc_q;
    best_sum_d   = best_sum_q;
    best_d       = best_q;
    have_d       = have_q;

    // Advance the read walk: up toward the root, then on to the next leaf.
    if (rd_en_o) begin
      if (step_q == lev_q) begin
        if ((state_q == ST_BUMP) || (leaf_q == last_leaf_q)) begin
          issue_done_d = 1'b1;
        end else begin
          leaf_d = leaf_q + 1'b1;
          walk_d = leaf_q + 1'b1;
          step_d = '0;
        end
      end else begin
        walk_d = parent;
        step_d = step_q + 1'b1;
      end
    end

    // Fold returned counter into the path sum; strict less keeps the first tie.
    if ((state_q == ST_SCAN) && tag_valid_q) begin
      if (tag_last_q) begin
        if (!have_q || (add_sum < best_sum_q)) begin
          have_d     = 1'b1;
          best_sum_d = add_sum;
          best_d     = tag_node_q;
        end
      end else begin
        acc_d = add_sum;
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          lev_d        = pick_lev;
          leaf_d       = NodeW'((32'd1 << pick_lev) - 32'd1);
          walk_d       = NodeW'((32'd1 << pick_lev) - 32'd1);
          last_leaf_d  = NodeW'((32'd2 << pick_lev) - 32'd2);
          step_d       = '0;
          issue_done_d = 1'b0;
          have_d       = 1'b0;
          state_d      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue_done_q && !tag_valid_q) begin
          walk_d       = best_q;
          step_d       = '0;
          issue_done_d = 1'b0;
          state_d      = ST_BUMP;
        end
      end
      ST_BUMP: begin
        if (issue_done_q && !tag_valid_q) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      lev_q        <= '0;
      step_q       <= '0;
      walk_q       <= '0;
      leaf_q       <= '0;
      last_leaf_q  <= '0;
      issue_done_q <= 1'b0;
      tag_valid_q  <= 1'b0;
      tag_first_q  <= 1'b0;
      tag_last_q   <= 1'b0;
      tag_node_q   <= '0;
      acc_q        <= '0;
      best_sum_q   <= '0;
      best_q       <= '0;
      have_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      lev_q        <= lev_d;
      step_q       <= step_d;
      walk_q       <= walk_d;
      leaf_q       <= leaf_d;
      last_leaf_q  <= last_leaf_d;
      issue_done_q <= issue_done_d;
      tag_valid_q  <= tag_valid_d;
      tag_first_q  <= tag_first_d;
      tag_last_q   <= tag_last_d;
      tag_node_q   <= tag_node_d;
      acc_q        <= acc_d;
      best_sum_q   <= best_sum_d;
      best_q       <= best_d;
      have_q       <= have_d;
    end
  end

`include "interrupt_tree_slot_allocator_assert.svh"

  `ITSA_ASSERT_NOW(a_idle_no_inflight, state_q == ST_IDLE, !tag_valid_q, "read in flight while idle")
  `ITSA_ASSERT_NOW(a_step_in_range, walking, step_q <= lev_q, "path step beyond chosen level")
  `ITSA_ASSERT_NEXT(a_scan_has_winner, (state_q == ST_SCAN) && (state_d == ST_BUMP), have_q, "bump without a chosen node")

endmodule

@@ bench/interrupt_tree_slot_allocator_tb.sv @@
// Self-checking bench for the interrupt tree slot allocator: directed and
// random intervals go in, each returned slot is compared against a local copy
// of the load tree. Depends on itsa_pkg, itsa_if.sv and the allocator RTL.
`timescale 1ns / 1ps

module interrupt_tree_slot_allocator_tb;
  import itsa_pkg::*;

  localparam int unsigned NodeCount   = (1 << (TopLevelDef + 1)) - 1;
  localparam int unsigned StallLimit  = 5000;
  localparam int unsigned DrainCycles = 250;
  localparam int unsigned RandomItems = 1130;
  localparam int unsigned PhaseCount  = 3;

  class tree_load_tracker;
    logic [LoadWidthDef-1:0] node_load [NodeCount];
    logic [SlotW-1:0]        pending_slots [$];
    int unsigned             errors;

    function new();
      foreach (node_load[i]) node_load[i] = '0;
      errors = 0;
    endfunction

    task report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // Walk every node of the chosen level, keep the lightest path (first wins
    // a tie), then bump that path with saturation.
    function int unsigned least_loaded_node(input logic [IntervalW-1:0] interval);
      int unsigned lvl, first, node, best, k, l;
      longint unsigned sum, best_sum;
      lvl = TopLevelDef;
      while (lvl > 0 && (1 << lvl) > interval) lvl--;
      first    = (1 << lvl) - 1;
      best     = first;
      best_sum = 0;
      for (k = 0; k < (1 << lvl); k++) begin
        node = first + k;
        sum  = 0;
        for (l = 0; l <= lvl; l++) begin
          sum += node_load[node];
          node = (node + 1) / 2 - 1;
        end
        if (k == 0 || sum < best_sum) begin
          best_sum = sum;
          best     = first + k;
        end
      end
      node = best;
      for (l = 0; l <= lvl; l++) begin
        if (node_load[node] != '1) node_load[node]++;
        node = (node + 1) / 2 - 1;
      end
      return best;
    endfunction

    function void book_interval(input logic [IntervalW-1:0] interval);
      int unsigned node;
      node = least_loaded_node(interval);
      pending_slots.push_back(node[SlotW-1:0]);
    endfunction

    task check_slot(input logic [SlotW-1:0] got);
      logic [SlotW-1:0] want;
      if (pending_slots.size() == 0) begin
        report_mismatch($sformatf("unexpected response slot=%0d", got));
      end else begin
        want = pending_slots.pop_front();
        if (got !== want)
          report_mismatch($sformatf("slot=%0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  itsa_req_if req_if ();
  itsa_rsp_if rsp_if ();

  interrupt_tree_slot_allocator DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  tree_load_tracker allocs = new();

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Receiver: roll the stall once per cycle.
  always @(negedge clk_i) begin
    rsp_if.ready <= rst_ni && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) allocs.check_slot(rsp_if.slot);
  end

  // Abort when neither channel moves for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("interrupt_tree_slot_allocator_tb: FAIL");
    $finish;
  end

  task send_request(input logic [IntervalW-1:0] interval);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.interval <= interval;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    allocs.book_interval(interval);
  endtask

  // Pick a level evenly, then an interval within it, so shallow trees get
  // as much traffic as the full-depth scan.
  function logic [IntervalW-1:0] random_interval();
    int unsigned lvl;
    lvl = $urandom_range(0, TopLevelDef);
    if (lvl == 0) return IntervalW'($urandom_range(0, 1));
    if (lvl == TopLevelDef) return IntervalW'($urandom_range(1 << lvl, 255));
    return IntervalW'($urandom_range(1 << lvl, (2 << lvl) - 1));
  endfunction

  initial begin : stimulus
    int unsigned directed [];
    int unsigned send_pcts [PhaseCount];
    int unsigned recv_pcts [PhaseCount];
    int unsigned phase, n;

    directed  = '{0, 1, 2, 3, 4, 5, 7, 8, 15, 16, 31, 32, 33,
                  63, 64, 85, 127, 128, 170, 255, 32, 32, 255};
    send_pcts = '{19, 81, 0};
    recv_pcts = '{81, 19, 0};

    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.interval = '0;
    send_idle_pct   = send_pcts[0];
    recv_idle_pct   = recv_pcts[0];
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[i]) send_request(IntervalW'(directed[i]));

    for (phase = 0; phase < PhaseCount; phase++) begin
      send_idle_pct = send_pcts[phase];
      recv_idle_pct = recv_pcts[phase];
      for (n = 0; n < RandomItems / PhaseCount; n++) send_request(random_interval());
    end

    @(negedge clk_i);
    req_if.valid <= 1'b0;

    while (allocs.pending_slots.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (allocs.errors == 0) begin
      $display("interrupt_tree_slot_allocator_tb: PASS");
    end else begin
      $display("interrupt_tree_slot_allocator_tb: FAIL");
    end
    $finish;
  end

endmodule
